// File: hw/rtl/grid_peak_valley_detect_assert.svh
// ----------------------------------------------------------------------------
// grid_peak_valley_detect assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_PEAK_VALLEY_DETECT_ASSERT_SVH
`define GRID_PEAK_VALLEY_DETECT_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define GPVD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gpvd_pkg.sv
// ----------------------------------------------------------------------------
// gpvd_pkg
// Shared constants, register indexes and helpers of the peak/valley detector.
// ----------------------------------------------------------------------------
package gpvd_pkg;

    localparam int unsigned MAX_DIM_DEF     = 64;
    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned CFG_DIM_BITS    = 7;
    localparam int unsigned CFG_ADDR_BITS   = 2;
    localparam int unsigned IDX_BITS        = 6;

    localparam logic [CFG_DIM_BITS-1:0] DIM_RESET = 7'd64;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_MODE = 2'd2
    } t_cfg_idx;

    // Last valid index for a programmed dimension: 0 acts as 1, clamp to max.
    function automatic int unsigned dim_last(input logic [CFG_DIM_BITS-1:0] v,
                                             input int unsigned max_dim);
        int unsigned val;
        val = int'(v);
        if (val == 0) begin
            return 0;
        end
        if (val > max_dim) begin
            return max_dim - 1;
        end
        return val - 1;
    endfunction

endpackage

// File: hw/rtl/gpvd_lines.sv
// ----------------------------------------------------------------------------
// gpvd_lines
// Two line RAMs (row above, centre row) with registered, write-bypassed reads.
// ----------------------------------------------------------------------------
module gpvd_lines #(
    parameter int unsigned MAX_DIM     = gpvd_pkg::MAX_DIM_DEF,
    parameter int unsigned SAMPLE_BITS = gpvd_pkg::SAMPLE_BITS_DEF,
    localparam int unsigned AW         = $clog2(MAX_DIM)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_wcentre,  // new centre-row sample
    input  logic signed [SAMPLE_BITS-1:0] i_wabove,   // old centre moves up
    input  logic [AW-1:0]                 i_raddr,    // column of next beat
    input  logic [AW-1:0]                 i_raddr_rt, // column to its right
    output logic signed [SAMPLE_BITS-1:0] o_centre,
    output logic signed [SAMPLE_BITS-1:0] o_above,
    output logic signed [SAMPLE_BITS-1:0] o_right
);

    logic signed [SAMPLE_BITS-1:0] r_mem_cen [0:MAX_DIM-1];
    logic signed [SAMPLE_BITS-1:0] r_mem_abv [0:MAX_DIM-1];
    logic signed [SAMPLE_BITS-1:0] r_centre;
    logic signed [SAMPLE_BITS-1:0] r_above;
    logic signed [SAMPLE_BITS-1:0] r_right;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_cen[i_waddr] <= i_wcentre;
            r_mem_abv[i_waddr] <= i_wabove;
        end
    end

    // read-during-write returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_centre <= i_wcentre;
            r_above  <= i_wabove;
        end else begin
            r_centre <= r_mem_cen[i_raddr];
            r_above  <= r_mem_abv[i_raddr];
        end
        if (i_we && (i_waddr == i_raddr_rt)) begin
            r_right <= i_wcentre;
        end else begin
            r_right <= r_mem_cen[i_raddr_rt];
        end
    end

    assign o_centre = r_centre;
    assign o_above  = r_above;
    assign o_right  = r_right;

endmodule

// File: hw/rtl/gpvd_skid.sv
// ----------------------------------------------------------------------------
// gpvd_skid
// Result register with one skid entry on the output stream.
// ----------------------------------------------------------------------------
module gpvd_skid #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [W-1:0] o_m_tdata
);

    logic         r_out_valid;
    logic         r_skid_valid;
    logic [W-1:0] r_out_data;
    logic [W-1:0] r_skid_data;
    logic         pop;

    assign pop = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    assign o_ready    = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: hw/rtl/grid_peak_valley_detect.sv
// ----------------------------------------------------------------------------
// grid_peak_valley_detect
// Four-neighbour strict peak / valley detector over a raster sample stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (i_s_*): one signed elevation sample per beat, raster order,
//    rows_in_use x cols_in_use samples per frame; frames follow back to back.
//  - Output stream (o_m_*): one beat per interior cell that is strictly above
//    (peak mode) or strictly below (valley mode) its four neighbours, carrying
//    row, column and value. Border cells are never reported.
//  - Config port: write-only, reg 0 rows, reg 1 cols, reg 2 mode. Writing rows
//    or cols restarts the frame at row 0, column 0. Write only when idle.
//  - Throughput: one sample per clock while ready. The centre line RAM is read at
//    two columns each cycle (cell and its right neighbour), so no beat has to wait.
//  - Output: a hit is tested as the sample below the cell is accepted and is
//    registered before it is presented on o_m_tvalid.
//  - Stall: one result register plus one skid entry; o_s_tready drops only
//    while both hold a result the receiver has not taken.
//  - Reset (synchronous, active low): counters to zero, dimensions 64, peak
//    mode, output empty. Line RAMs are not cleared; no pass is needed.
// ----------------------------------------------------------------------------
`include "grid_peak_valley_detect_assert.svh"

module grid_peak_valley_detect #(
    parameter int unsigned MAX_DIM     = gpvd_pkg::MAX_DIM_DEF,
    parameter int unsigned SAMPLE_BITS = gpvd_pkg::SAMPLE_BITS_DEF,
    localparam int unsigned IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((2 * gpvd_pkg::IDX_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [gpvd_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [gpvd_pkg::CFG_DIM_BITS-1:0]   i_cfg_wdata,
    // sample stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [IN_W-1:0]                     i_s_tdata,   // [elevation]
    // hit stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [OUT_W-1:0]                    o_m_tdata    // [hit_row, hit_col, hit_value]
);

    localparam int unsigned AW = $clog2(MAX_DIM);
    localparam int unsigned IB = gpvd_pkg::IDX_BITS;

    // ---------------- configuration ----------------
    logic [AW-1:0] r_rows_m1;   // last row index of the frame
    logic [AW-1:0] r_cols_m1;   // last column index of the frame
    logic          r_find_valleys;
    logic          dim_wr;

    assign dim_wr = i_cfg_wr_en &&
                    ((gpvd_pkg::t_cfg_idx'(i_cfg_addr) == gpvd_pkg::CFG_ROWS) ||
                     (gpvd_pkg::t_cfg_idx'(i_cfg_addr) == gpvd_pkg::CFG_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1      <= AW'(gpvd_pkg::dim_last(gpvd_pkg::DIM_RESET, MAX_DIM));
            r_cols_m1      <= AW'(gpvd_pkg::dim_last(gpvd_pkg::DIM_RESET, MAX_DIM));
            r_find_valleys <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (gpvd_pkg::t_cfg_idx'(i_cfg_addr))
                gpvd_pkg::CFG_ROWS: begin
                    r_rows_m1 <= AW'(gpvd_pkg::dim_last(i_cfg_wdata, MAX_DIM));
                end
                gpvd_pkg::CFG_COLS: begin
                    r_cols_m1 <= AW'(gpvd_pkg::dim_last(i_cfg_wdata, MAX_DIM));
                end
                gpvd_pkg::CFG_MODE: begin
                    r_find_valleys <= i_cfg_wdata[0];
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // ---------------- raster position ----------------
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] n_row;
    logic [AW-1:0] n_col;
    logic [AW-1:0] col_rt;
    logic          accept;
    logic          last_col;

    assign accept   = i_s_tvalid && o_s_tready;
    assign last_col = (r_col == r_cols_m1);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (dim_wr) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = (r_row == r_rows_m1) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // right-hand column of the next beat; only used when it lies inside the row
    assign col_rt = (n_col == AW'(MAX_DIM - 1)) ? '0 : n_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line buffers and window ----------------
    logic signed [SAMPLE_BITS-1:0] elevation;
    logic signed [SAMPLE_BITS-1:0] centre;
    logic signed [SAMPLE_BITS-1:0] above;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] r_left;   // old centre-row value at col-1

    assign elevation = i_s_tdata[SAMPLE_BITS-1:0];

    gpvd_lines #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lines (
        .i_clk      (i_clk),
        .i_we       (accept),
        .i_waddr    (r_col),
        .i_wcentre  (elevation),
        .i_wabove   (centre),
        .i_raddr    (n_col),
        .i_raddr_rt (col_rt),
        .o_centre   (centre),
        .o_above    (above),
        .o_right    (right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (accept) begin
            r_left <= centre;
        end
    end

    // ---------------- extremum test ----------------
    logic          interior;
    logic          is_peak;
    logic          is_valley;
    logic          hit;
    logic [AW-1:0] row_m1;
    logic [OUT_W-1:0] hit_data;

    // cell sits one row up; right neighbour exists only below the last column
    assign interior  = (r_row >= AW'(2)) && (r_col != '0) && (r_col < r_cols_m1);
    assign is_peak   = (centre > above) && (centre > elevation) &&
                       (centre > r_left) && (centre > right);
    assign is_valley = (centre < above) && (centre < elevation) &&
                       (centre < r_left) && (centre < right);
    assign hit       = accept && interior && (r_find_valleys ? is_valley : is_peak);

    assign row_m1   = r_row - 1'b1;
    assign hit_data = OUT_W'({centre, IB'(r_col), IB'(row_m1)});

    gpvd_skid #(
        .W (OUT_W)
    ) u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (hit),
        .i_data     (hit_data),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ---------------- assertions ----------------
    `GPVD_ASSERT_ALWAYS(a_col_in_frame, r_col <= r_cols_m1, "column counter past frame width")

    `GPVD_ASSERT_ALWAYS(a_row_in_frame, r_row <= r_rows_m1, "row counter past frame height")

    `GPVD_ASSERT_NEXT(a_row_advance,
        accept && last_col && (r_row != r_rows_m1) && !i_cfg_wr_en,
        (r_col == '0) && (r_row == $past(r_row) + 1'b1),
        "raster position did not advance to next row")

    `GPVD_ASSERT_ALWAYS(a_stall_has_result, o_s_tready || o_m_tvalid,
        "input stalled with no result pending")

endmodule

// File: sim/grid_peak_valley_detect_tb.sv
// ----------------------------------------------------------------------------
// grid_peak_valley_detect_tb
// Self-checking bench for the four-neighbour peak/valley detector. Raster
// frames of signed samples are streamed in through a bursty driver; a
// monitor predicts every hit beat from its own copy of the line buffers and
// counters, and checks the hit stream field by field against that forecast.
// ----------------------------------------------------------------------------
module grid_peak_valley_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_DIM     = 64;
    localparam int SAMPLE_W     = 16;
    localparam int IN_W         = 16;
    localparam int OUT_W        = 32;
    localparam int LIMIT_CYCLES = 500000;
    localparam int LONG_HOLD    = 200;
    localparam int RAND_TARGET  = 1250;

    // index beyond the register map, must be ignored by the block
    localparam logic [gpvd_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE = 2'd3;

    // content style of generated frames
    typedef enum int {
        STYLE_RANDOM,
        STYLE_NARROW,    // tiny range, lots of ties against the strict test
        STYLE_CHECKER,   // alternating high/low cells, dense hits
        STYLE_EXTREME    // full-scale, near-zero and random values
    } t_fill;

    typedef struct {
        logic [5:0]                 row;
        logic [5:0]                 col;
        logic signed [SAMPLE_W-1:0] value;
    } t_hit;

    // ---------------------------------------------------------------- signals
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [gpvd_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr  = '0;
    logic [gpvd_pkg::CFG_DIM_BITS-1:0]  i_cfg_wdata = '0;
    logic                               i_s_tvalid  = 1'b0;
    logic                               o_s_tready;
    logic [IN_W-1:0]                    i_s_tdata   = '0;   // [15:0] elevation
    logic                               o_m_tvalid;
    logic                               i_m_tready  = 1'b0;
    logic [OUT_W-1:0]                   o_m_tdata;          // [5:0] hit_row, [11:6] hit_col,
                                                            // [27:12] hit_value, [31:28] zero

    grid_peak_valley_detect DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------- shared state
    logic [SAMPLE_W-1:0] sample_q[$];      // samples waiting for the driver
    t_hit                expected_hits[$]; // forecast hit beats, oldest first
    int                  err_count = 0;
    int                  cycle_count = 0;

    // traffic knobs, changed by the stimulus only while the block is idle
    int gap_max   = 0;
    int burst_max = 0;
    int ready_pct = 100;
    bit hold_req  = 1'b0;

    // 0 behaves as 1, anything above the grid size as the grid size
    function automatic int grid_extent(input logic [gpvd_pkg::CFG_DIM_BITS-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > GRID_DIM) begin
            return GRID_DIM;
        end
        return int'(v);
    endfunction

    // ------------------------------------------------------------- driver
    // Bursts of random length, random gaps between them. valid only drops
    // once the current beat has gone in.
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            gap_left   = 0;
            burst_left = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0) begin
                i_s_tvalid <= 1'b0;
                gap_left--;
            end else if (sample_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= sample_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(burst_max);
                    gap_left   = $urandom_range(gap_max);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------------- receiver
    // Random stalls at a per-phase rate, plus one long hold-off on request
    // so the output side backs up into the sample stream.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) < ready_pct);
        end
    end

    // ---------------------------------------------------- grid predictor
    logic signed [SAMPLE_W-1:0]        ln_above[GRID_DIM];
    logic signed [SAMPLE_W-1:0]        ln_centre[GRID_DIM];
    logic signed [SAMPLE_W-1:0]        left_reg;
    logic [5:0]                        row_pos;
    logic [5:0]                        col_pos;
    logic [gpvd_pkg::CFG_DIM_BITS-1:0] rows_cfg;
    logic [gpvd_pkg::CFG_DIM_BITS-1:0] cols_cfg;
    logic                              valley_mode;

    task automatic reset_grid();
        for (int k = 0; k < GRID_DIM; k++) begin
            ln_above[k]  = '0;
            ln_centre[k] = '0;
        end
        left_reg    = '0;
        row_pos     = '0;
        col_pos     = '0;
        rows_cfg    = gpvd_pkg::DIM_RESET;
        cols_cfg    = gpvd_pkg::DIM_RESET;
        valley_mode = 1'b0;
    endtask

    // One accepted sample: test the cell above it if interior, then roll
    // the line buffers and advance the raster position.
    task automatic grid_step(input logic signed [SAMPLE_W-1:0] smp);
        int                         r;
        int                         c;
        int                         nrows;
        int                         ncols;
        logic signed [SAMPLE_W-1:0] centre;
        logic signed [SAMPLE_W-1:0] above;
        logic signed [SAMPLE_W-1:0] right;
        logic                       hit;
        t_hit                       h;
        r      = int'(row_pos);
        c      = int'(col_pos);
        nrows  = grid_extent(rows_cfg);
        ncols  = grid_extent(cols_cfg);
        centre = ln_centre[c];
        above  = ln_above[c];
        if (r >= 2 && r < nrows && c >= 1 && c + 1 < ncols) begin
            right = ln_centre[c+1];
            if (valley_mode) begin
                hit = centre < above && centre < smp && centre < left_reg && centre < right;
            end else begin
                hit = centre > above && centre > smp && centre > left_reg && centre > right;
            end
            if (hit) begin
                h.row   = 6'(r - 1);
                h.col   = 6'(c);
                h.value = centre;
                expected_hits.push_back(h);
            end
        end
        left_reg     = centre;
        ln_above[c]  = centre;
        ln_centre[c] = smp;
        if (c + 1 >= ncols) begin
            col_pos = '0;
            row_pos = (r + 1 >= nrows) ? 6'd0 : 6'(r + 1);
        end else begin
            col_pos = 6'(c + 1);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------ monitor
    // Sees config writes, sample beats and hit beats at the same edge the
    // block does. Forecast goes in before the check, so a same-edge result
    // would still find its expectation.
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            reset_grid();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    gpvd_pkg::CFG_ROWS: begin
                        rows_cfg = i_cfg_wdata;
                        row_pos  = '0;
                        col_pos  = '0;
                    end
                    gpvd_pkg::CFG_COLS: begin
                        cols_cfg = i_cfg_wdata;
                        row_pos  = '0;
                        col_pos  = '0;
                    end
                    gpvd_pkg::CFG_MODE: begin
                        valley_mode = i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                grid_step(i_s_tdata[SAMPLE_W-1:0]);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_hits.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected hit beat, expected none got %h",
                             $time, o_m_tdata);
                end else begin
                    want = expected_hits.pop_front();
                    check_field("hit_row", int'(want.row), int'(o_m_tdata[5:0]));
                    check_field("hit_col", int'(want.col), int'(o_m_tdata[11:6]));
                    check_field("hit_value", int'(want.value),
                                int'($signed(o_m_tdata[27:12])));
                end
            end
        end
    end

    // ------------------------------------------------------------ timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ----------------------------------------------------------- stimulus
    task automatic write_reg(input logic [gpvd_pkg::CFG_ADDR_BITS-1:0] idx,
                             input logic [gpvd_pkg::CFG_DIM_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // wait for all samples in and all hits out, then let the pipe empty
    task automatic settle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_s_tvalid || expected_hits.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] make_sample(input t_fill fill,
                                                        input int r, input int c);
        int t;
        case (fill)
            STYLE_NARROW: begin
                t = int'($urandom_range(4)) - 2;
            end
            STYLE_CHECKER: begin
                if ((r + c) % 2 == 1) begin
                    t = 16384 + int'($urandom_range(16383));
                end else begin
                    t = -32768 + int'($urandom_range(49151));
                end
            end
            STYLE_EXTREME: begin
                case ($urandom_range(4))
                    0:       t = -32768;
                    1:       t = 32767;
                    2:       t = 0;
                    3:       t = -1;
                    default: t = int'($urandom_range(65535));
                endcase
            end
            default: begin
                t = int'($urandom_range(65535));
            end
        endcase
        return t[SAMPLE_W-1:0];
    endfunction

    task automatic queue_samples(input t_fill fill, input int count, input int ncols);
        for (int k = 0; k < count; k++) begin
            sample_q.push_back(make_sample(fill, k / ncols, k % ncols));
        end
    endtask

    initial begin
        int                                phase;
        int                                sel;
        int                                count;
        int                                area;
        int                                rand_items;
        t_fill                             fill;
        logic [gpvd_pkg::CFG_DIM_BITS-1:0] cur_rows;
        logic [gpvd_pkg::CFG_DIM_BITS-1:0] cur_cols;
        logic [gpvd_pkg::CFG_DIM_BITS-1:0] odd_dim;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // one sample at the reset size, then a size write must restart the frame
        sample_q.push_back(16'h1234);
        settle();
        write_reg(CFG_SPARE, 7'h7F);
        write_reg(gpvd_pkg::CFG_ROWS, 7'd3);
        write_reg(gpvd_pkg::CFG_COLS, 7'd3);

        // 3x3 peak: full-scale centre inside a floor of minimum values
        for (int k = 0; k < 9; k++) begin
            sample_q.push_back((k == 4) ? 16'h7FFF : 16'h8000);
        end
        settle();

        // 3x3 valley, mode flipped mid-frame: must not restart the raster
        for (int k = 0; k < 4; k++) begin
            sample_q.push_back(16'h7FFF);
        end
        settle();
        write_reg(gpvd_pkg::CFG_MODE, 7'd1);
        sample_q.push_back(16'h8000);
        for (int k = 0; k < 4; k++) begin
            sample_q.push_back(16'h7FFF);
        end
        settle();

        // zero columns act as one, oversize rows clamp: nothing reported
        write_reg(gpvd_pkg::CFG_COLS, 7'd0);
        write_reg(gpvd_pkg::CFG_ROWS, 7'd127);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h0000);
        settle();

        // two rows only: too thin for any interior cell
        write_reg(gpvd_pkg::CFG_ROWS, 7'd2);
        write_reg(gpvd_pkg::CFG_COLS, 7'd65);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        settle();

        // --- random phases ---
        cur_rows   = 7'd2;
        cur_cols   = 7'd65;
        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_TARGET) begin
            phase++;
            case ($urandom_range(3))
                0: begin
                    gap_max   = 0;
                    burst_max = 0;
                    ready_pct = 100;
                end
                1: begin
                    gap_max   = 3;
                    burst_max = 8;
                    ready_pct = 70;
                end
                2: begin
                    gap_max   = 10;
                    burst_max = 3;
                    ready_pct = 30;
                end
                default: begin
                    gap_max   = 1;
                    burst_max = 20;
                    ready_pct = 90;
                end
            endcase

            if ($urandom_range(1) == 1) begin
                write_reg(gpvd_pkg::CFG_MODE, 7'($urandom_range(127)));
            end

            fill = t_fill'($urandom_range(3));
            sel  = $urandom_range(9);
            if (phase == 4) begin
                // back-pressure phase: dense hits, no gaps, receiver holds off
                cur_rows  = 7'd8;
                cur_cols  = 7'd8;
                fill      = STYLE_CHECKER;
                gap_max   = 0;
                burst_max = 0;
                ready_pct = 100;
                write_reg(gpvd_pkg::CFG_ROWS, cur_rows);
                write_reg(gpvd_pkg::CFG_COLS, cur_cols);
                hold_req  = 1'b1;
                count     = 3 * 64;
            end else begin
                case (sel)
                    6: begin
                        cur_rows = 7'd64;
                        cur_cols = 7'($urandom_range(3, 4));
                    end
                    7: begin
                        cur_rows = 7'($urandom_range(3, 4));
                        cur_cols = 7'd64;
                    end
                    8: begin
                        case ($urandom_range(3))
                            0:       odd_dim = 7'd0;
                            1:       odd_dim = 7'd1;
                            2:       odd_dim = 7'd2;
                            default: odd_dim = 7'($urandom_range(65, 127));
                        endcase
                        if ($urandom_range(1) == 1) begin
                            cur_rows = odd_dim;
                            cur_cols = 7'($urandom_range(3, 8));
                        end else begin
                            cur_rows = 7'($urandom_range(3, 8));
                            cur_cols = odd_dim;
                        end
                    end
                    9: begin
                        // keep the current frame running
                        if (fill == STYLE_CHECKER) begin
                            fill = STYLE_RANDOM;
                        end
                    end
                    default: begin
                        cur_rows = 7'($urandom_range(3, 8));
                        cur_cols = 7'($urandom_range(3, 8));
                    end
                endcase
                if (sel != 9) begin
                    // sometimes only one dimension changes
                    if ($urandom_range(3) != 0) begin
                        write_reg(gpvd_pkg::CFG_ROWS, cur_rows);
                    end
                    write_reg(gpvd_pkg::CFG_COLS, cur_cols);
                end
                area = grid_extent(cur_rows) * grid_extent(cur_cols);
                if (sel == 6 || sel == 7) begin
                    count = area;
                end else if (sel == 8 || area > 256) begin
                    count = $urandom_range(5, 30);
                end else begin
                    count = area * $urandom_range(1, 3) + $urandom_range(2 * grid_extent(cur_cols));
                end
            end

            queue_samples(fill, count, grid_extent(cur_cols));
            rand_items += count;
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
